// File: rtl/apt_pkg.sv
package apt_pkg;

  localparam int unsigned DATA_W = 32;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SINGULAR = 2'd1,
    STATUS_SAT      = 2'd2
  } status_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_COEF_A  = 3'd0,
    REG_COEF_B  = 3'd1,
    REG_COEF_C  = 3'd2,
    REG_COEF_D  = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5
  } reg_idx_t;

  // mode bits
  localparam int unsigned MODE_DIST_BIT = 0;
  localparam int unsigned MODE_INV_BIT  = 1;

endpackage

// File: rtl/affine_point_transform_top.sv
// 2D affine point transform with matrix inverse, signed fixed point with FRAC_BITS
// fractional bits. One point enters per cycle and passes in turn through the input register,
// multiplier bank, adder tree and saturation/output register;
// the whole pipe stalls only while the output register holds an untaken result.
// The inverse matrix is computed in the background by a sequencer with one shared
// 32x32 multiplier and a one-bit-per-cycle 64-bit divider: after reset and after
// every configuration write, in_ready stays low until the inverse is ready (the
// sequencer stops early when the matrix is singular).
module affine_point_transform_top import apt_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_w,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_w,
  output logic [1:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam logic signed [31:0] ONE    = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] S32MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32MIN = 32'sh80000000;

  // ---------------- configuration registers ----------------
  logic signed [31:0] ca_r, cb_r, cc_r, cd_r, tx_r, ty_r;
  logic cfg_xfer;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_r <= ONE;
      cb_r <= '0;
      cc_r <= '0;
      cd_r <= ONE;
      tx_r <= '0;
      ty_r <= '0;
    end else if (cfg_xfer) begin
      case (cfg_index)
        REG_COEF_A:  ca_r <= cfg_data;
        REG_COEF_B:  cb_r <= cfg_data;
        REG_COEF_C:  cc_r <= cfg_data;
        REG_COEF_D:  cd_r <= cfg_data;
        REG_SHIFT_X: tx_r <= cfg_data;
        REG_SHIFT_Y: ty_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- inverse sequencer ----------------
  // job 0: determinant; jobs 1..6: a', b', c', d', tx', ty'
  // each job forms num = X1*Y1 - X2*Y2; jobs 1..6 then divide it by dq
  typedef enum logic [2:0] {
    ST_MUL1, ST_MUL2, ST_SUB, ST_DIV, ST_STORE, ST_DONE
  } seq_state_t;

  seq_state_t         st_r;
  logic [2:0]         job_r;
  logic signed [63:0] prod_r;
  logic signed [65:0] acc_r;
  logic [63:0]        dqmag_r;
  logic               dqneg_r;
  logic [63:0]        quo_r;
  logic [63:0]        rem_r;
  logic               qneg_r;
  logic [5:0]         cnt_r;
  logic               inv_done_r;
  logic               sing_r;
  logic               ov_lin_r;
  logic               ov_tr_r;
  logic signed [31:0] inv_r [6];

  logic signed [31:0] op_x1, op_y1, op_x2, op_y2, mul_a, mul_b;
  logic signed [65:0] num;
  logic [63:0]        num_mag;
  logic [64:0]        rem_sh;
  logic [64:0]        rem_sub;
  logic               q_bit;
  logic               q_sat;
  logic [31:0]        q_val;
  logic [2:0]         wr_idx;

  always_comb begin
    op_x1 = '0; op_y1 = '0; op_x2 = '0; op_y2 = '0;
    case (job_r)
      3'd0: begin op_x1 = ca_r; op_y1 = cd_r; op_x2 = cb_r; op_y2 = cc_r; end
      3'd1: begin op_x1 = cd_r; op_y1 = ONE; end
      3'd2: begin op_x2 = cb_r; op_y2 = ONE; end
      3'd3: begin op_x2 = cc_r; op_y2 = ONE; end
      3'd4: begin op_x1 = ca_r; op_y1 = ONE; end
      3'd5: begin op_x1 = cc_r; op_y1 = ty_r; op_x2 = cd_r; op_y2 = tx_r; end
      3'd6: begin op_x1 = cb_r; op_y1 = tx_r; op_x2 = ca_r; op_y2 = ty_r; end
      default: ;
    endcase
    mul_a = (st_r == ST_MUL1) ? op_x1 : op_x2;
    mul_b = (st_r == ST_MUL1) ? op_y1 : op_y2;

    num     = acc_r - 66'(prod_r);
    num_mag = num[65] ? 64'(-num) : num[63:0];

    rem_sh  = {rem_r, quo_r[63]};
    rem_sub = rem_sh - {1'b0, dqmag_r};
    q_bit   = !rem_sub[64];

    if (qneg_r) q_sat = (|quo_r[63:32]) || (quo_r[31] && (|quo_r[30:0]));
    else        q_sat = |quo_r[63:31];
    if (q_sat)       q_val = qneg_r ? S32MIN : S32MAX;
    else if (qneg_r) q_val = -quo_r[31:0];
    else             q_val = quo_r[31:0];
    wr_idx = job_r - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_xfer) begin
      st_r       <= ST_MUL1;
      job_r      <= '0;
      inv_done_r <= 1'b0;
      sing_r     <= 1'b0;
      ov_lin_r   <= 1'b0;
      ov_tr_r    <= 1'b0;
      cnt_r      <= '0;
    end else begin
      case (st_r)
        ST_MUL1: begin
          prod_r <= mul_a * mul_b;
          st_r   <= ST_MUL2;
        end
        ST_MUL2: begin
          acc_r  <= 66'(prod_r);
          prod_r <= mul_a * mul_b;
          st_r   <= ST_SUB;
        end
        ST_SUB: begin
          if (job_r == 3'd0) begin
            // dq = det / 2^F truncated toward zero
            dqmag_r <= num_mag >> FRAC_BITS;
            dqneg_r <= num[65];
            if ((num_mag >> FRAC_BITS) == 64'd0) begin
              sing_r     <= 1'b1;
              inv_done_r <= 1'b1;
              st_r       <= ST_DONE;
            end else begin
              job_r <= 3'd1;
              st_r  <= ST_MUL1;
            end
          end else begin
            quo_r  <= num_mag;
            rem_r  <= '0;
            qneg_r <= num[65] ^ dqneg_r;
            cnt_r  <= '0;
            st_r   <= ST_DIV;
          end
        end
        ST_DIV: begin
          quo_r <= {quo_r[62:0], q_bit};
          rem_r <= q_bit ? rem_sub[63:0] : rem_sh[63:0];
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) st_r <= ST_STORE;
        end
        ST_STORE: begin
          inv_r[wr_idx] <= q_val;
          if (job_r >= 3'd5) ov_tr_r  <= ov_tr_r  | q_sat;
          else               ov_lin_r <= ov_lin_r | q_sat;
          if (job_r == 3'd6) begin
            inv_done_r <= 1'b1;
            st_r       <= ST_DONE;
          end else begin
            job_r <= job_r + 3'd1;
            st_r  <= ST_MUL1;
          end
        end
        ST_DONE: ;
        default: st_r <= ST_MUL1;
      endcase
    end
  end

  // ---------------- forward pipeline ----------------
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en && inv_done_r;

  // stage 1: operands and coefficients
  logic               v1_r, sing1_r, ov1_r;
  logic signed [31:0] x1_r, y1_r, w1_r;
  logic signed [31:0] ma1_r, mb1_r, mc1_r, md1_r, mtx1_r, mty1_r;

  // stage 2: products
  logic               v2_r, sing2_r, ov2_r;
  logic signed [31:0] w2_r;
  logic signed [63:0] pxa_r, pyc_r, pwt_r, pxb_r, pyd_r, pwu_r;

  // stage 3: sums, floor-shifted
  logic               v3_r, sing3_r, ov3_r;
  logic signed [31:0] w3_r;
  logic signed [65:0] sx3_r, sy3_r;

  logic               use_t, inv_m;
  logic signed [65:0] sum_x, sum_y;
  logic               satx, saty;

  always_comb begin
    use_t = !in_mode[MODE_DIST_BIT];
    inv_m = in_mode[MODE_INV_BIT];
    sum_x = 66'(pxa_r) + 66'(pyc_r) + 66'(pwt_r);
    sum_y = 66'(pxb_r) + 66'(pyd_r) + 66'(pwu_r);
    satx  = !((&sx3_r[65:31]) || !(|sx3_r[65:31]));
    saty  = !((&sy3_r[65:31]) || !(|sy3_r[65:31]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1_r      <= in_valid && in_ready;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      out_valid <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= in_x;
      y1_r    <= in_y;
      w1_r    <= in_w;
      sing1_r <= inv_m && sing_r;
      ov1_r   <= inv_m && (ov_lin_r || (use_t && ov_tr_r));
      ma1_r   <= inv_m ? inv_r[0] : ca_r;
      mb1_r   <= inv_m ? inv_r[1] : cb_r;
      mc1_r   <= inv_m ? inv_r[2] : cc_r;
      md1_r   <= inv_m ? inv_r[3] : cd_r;
      mtx1_r  <= !use_t ? 32'sd0 : (inv_m ? inv_r[4] : tx_r);
      mty1_r  <= !use_t ? 32'sd0 : (inv_m ? inv_r[5] : ty_r);

      sing2_r <= sing1_r;
      ov2_r   <= ov1_r;
      w2_r    <= w1_r;
      pxa_r   <= x1_r * ma1_r;
      pyc_r   <= y1_r * mc1_r;
      pwt_r   <= w1_r * mtx1_r;
      pxb_r   <= x1_r * mb1_r;
      pyd_r   <= y1_r * md1_r;
      pwu_r   <= w1_r * mty1_r;

      sing3_r <= sing2_r;
      ov3_r   <= ov2_r;
      w3_r    <= w2_r;
      sx3_r   <= sum_x >>> FRAC_BITS;
      sy3_r   <= sum_y >>> FRAC_BITS;

      out_w <= w3_r;
      if (sing3_r) begin
        out_x      <= '0;
        out_y      <= '0;
        out_status <= STATUS_SINGULAR;
      end else begin
        out_x      <= satx ? (sx3_r[65] ? S32MIN : S32MAX) : sx3_r[31:0];
        out_y      <= saty ? (sy3_r[65] ? S32MIN : S32MAX) : sy3_r[31:0];
        out_status <= (ov3_r || satx || saty) ? STATUS_SAT : STATUS_OK;
      end
    end
  end

  // ---------------- assertions ----------------
  a_in_needs_inverse: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> inv_done_r)
    else $error("input transfer before inverse ready");

  a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_xfer |=> !inv_done_r)
    else $error("config write did not restart inverse");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_SINGULAR) |-> (out_x == 0 && out_y == 0))
    else $error("singular result with nonzero coordinates");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    inv_done_r |-> (st_r == ST_DONE))
    else $error("inverse flagged ready while sequencer busy");

endmodule
